// ----- rtl/lud_pkg.sv -----
`timescale 1ns / 1ps

package lud_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int EFF_WIDTH   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int CELLS       = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(MAX_ORDER + 1);
  localparam int LCNT_W      = $clog2(CELLS + 1);
  localparam int SIZE_W      = 4;
  localparam int DIV_N       = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_N);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (EFF_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;
  localparam logic signed [63:0] Q_ONE   = 64'sd1 <<< FRAC_BITS;

  // working store write sources
  localparam logic [1:0] WR_LOAD = 2'd0;
  localparam logic [1:0] WR_ZERO = 2'd1;
  localparam logic [1:0] WR_UPD  = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [1:0]        wr_sel;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              piv_load;
    logic              div_start;
    logic              low_wr;
    logic              mul_en;
    logic              flag_clr;
    logic              flag_set;
    logic              out_cap;
    logic              out_below;
    logic              out_diag;
    logic              out_last;
  } lud_cmd_t;

  typedef struct packed {
    logic piv_zero;
    logic div_done;
  } lud_sts_t;

  // saturate to the value range, sign-extended to the field width
  function automatic logic signed [DATA_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    begin
      t = v;
      if (v > VAL_MAX) t = VAL_MAX;
      if (v < VAL_MIN) t = VAL_MIN;
      return t[DATA_W-1:0];
    end
  endfunction

  // row-major address of (r, c) for order n
  function automatic logic [ADDR_W-1:0] lin(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c,
                                            input logic [CNT_W-1:0] n);
    logic [2*CNT_W:0] t;
    begin
      t = (2*CNT_W+1)'(r) * (2*CNT_W+1)'(n) + (2*CNT_W+1)'(c);
      return t[ADDR_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/lu_decomposition_doolittle_unit.sv -----
`timescale 1ns / 1ps

// LU factoriser (unit-lower L, upper U), no pivoting, signed Q16.16.
// Input: raise start with in_element_value and in_last_element while busy
// is low; each request loads one element in row-major order, one cycle
// each. Elements past n*n are dropped; the request marked last starts the
// run, and positions not loaded in this run are taken as zero.
// Configuration: cfg_matrix_size (order n, 1..8) is written when cfg_valid
// and cfg_ready are high; cfg_ready is low while busy.
// Run: a zero fill of up to n*n positions, then per column a pivot read;
// per row below the pivot a wait on the 48-step bit-serial divider
// (skipped when the pivot is zero), then a read, multiply and write per
// updated element through the single multiplier and store port pair.
// Results leave one at a time, n*n in all, each read from the store and
// then put on the out_ ports for one cycle with out_strobe high; the
// receiver cannot stall, so none are held back. out_last_result marks the
// last; out_pivot_error marks all results of a run that met a zero pivot.
// Reset: idle, order 8, no elements loaded; store contents are not cleared.
module lu_decomposition_doolittle_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lud_pkg::DATA_W-1:0]   in_element_value,
  input  logic                                in_last_element,
  output logic                                out_strobe,
  output logic signed [lud_pkg::DATA_W-1:0]   out_lower_value,
  output logic signed [lud_pkg::DATA_W-1:0]   out_upper_value,
  output logic                                out_last_result,
  output logic                                out_pivot_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lud_pkg::SIZE_W-1:0]          cfg_matrix_size
);

  lud_pkg::lud_cmd_t cmd;
  lud_pkg::lud_sts_t sts;

  lud_controller u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_last_element (in_last_element),
    .busy            (busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_matrix_size (cfg_matrix_size),
    .cmd             (cmd),
    .sts             (sts)
  );

  lud_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_element_value (in_element_value),
    .out_lower_value  (out_lower_value),
    .out_upper_value  (out_upper_value),
    .out_last_result  (out_last_result),
    .out_pivot_error  (out_pivot_error),
    .out_strobe       (out_strobe)
  );

endmodule

// ----- rtl/lud_divider.sv -----
`timescale 1ns / 1ps

module lud_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lud_pkg::DATA_W-1:0]   num,
  input  logic signed [lud_pkg::DATA_W-1:0]   den,
  output logic                                done,
  output logic signed [lud_pkg::DATA_W-1:0]   quot
);

  localparam int N = lud_pkg::DIV_N;
  localparam int W = lud_pkg::DATA_W;

  logic                         run_r, run_nxt;
  logic                         done_r, done_nxt;
  logic [lud_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                 rem_r, rem_nxt;
  logic [N-1:0]                 sh_r, sh_nxt;
  logic [W-1:0]                 den_r, den_nxt;
  logic                         neg_r, neg_nxt;
  logic [W:0]                   trial;
  logic [W-1:0]                 num_mag, den_mag;
  logic signed [63:0]           signed_q;

  assign num_mag = num[W-1] ? (~num + W'(1)) : num;
  assign den_mag = den[W-1] ? (~den + W'(1)) : den;
  assign trial   = {rem_r, sh_r[N-1]};

  // one quotient bit a cycle, restoring, on magnitudes
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start && !run_r) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      sh_nxt  = {num_mag, {lud_pkg::FRAC_BITS{1'b0}}};
      den_nxt = den_mag;
      neg_nxt = num[W-1] ^ den[W-1];
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
        sh_nxt  = {sh_r[N-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        sh_nxt  = {sh_r[N-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + lud_pkg::DIV_CNT_W'(1);
      if (cnt_r == lud_pkg::DIV_CNT_W'(N - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // apply sign and saturate
  assign signed_q = neg_r ? -$signed({{(64-N){1'b0}}, sh_r}) : $signed({{(64-N){1'b0}}, sh_r});
  assign quot     = lud_pkg::sat(signed_q);
  assign done     = done_r;

endmodule

// ----- rtl/lud_datapath.sv -----
`timescale 1ns / 1ps

module lud_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lud_pkg::lud_cmd_t                  cmd,
  output lud_pkg::lud_sts_t                  sts,
  input  logic signed [lud_pkg::DATA_W-1:0]  in_element_value,
  output logic signed [lud_pkg::DATA_W-1:0]  out_lower_value,
  output logic signed [lud_pkg::DATA_W-1:0]  out_upper_value,
  output logic                               out_last_result,
  output logic                               out_pivot_error,
  output logic                               out_strobe
);

  localparam int W = lud_pkg::DATA_W;

  logic signed [W-1:0] wm [lud_pkg::CELLS];
  logic signed [W-1:0] lm [lud_pkg::CELLS];
  logic signed [W-1:0] rd_a_r, rd_b_r, low_rd_r;
  logic signed [W-1:0] piv_r, mu_r, akj_r;
  logic signed [63:0]  prod_r;
  logic                flag_r;
  logic signed [W-1:0] wdata;
  logic signed [63:0]  prod_adj, prod_q, diff;
  logic                div_done;
  logic signed [W-1:0] div_quot;
  logic signed [W-1:0] out_lower_r, out_upper_r;
  logic                out_last_r, out_strobe_r;

  lud_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (rd_a_r),
    .den   (piv_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // truncate product toward zero, subtract, saturate
  assign prod_adj = prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0);
  assign prod_q   = prod_adj >>> lud_pkg::FRAC_BITS;
  assign diff     = $signed({{(64-W){akj_r[W-1]}}, akj_r}) - prod_q;

  always_comb begin
    case (cmd.wr_sel)
      lud_pkg::WR_LOAD: wdata = lud_pkg::sat($signed({{(64-W){in_element_value[W-1]}},
                                                      in_element_value}));
      lud_pkg::WR_ZERO: wdata = '0;
      lud_pkg::WR_UPD:  wdata = lud_pkg::sat(diff);
      default:          wdata = '0;
    endcase
  end

  // working store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      wm[cmd.wr_addr] <= wdata;
    end
    rd_a_r <= wm[cmd.rd_addr_a];
    rd_b_r <= wm[cmd.rd_addr_b];
  end

  // multiplier store
  always_ff @(posedge clk) begin
    if (cmd.low_wr) begin
      lm[cmd.wr_addr] <= mu_r;
    end
    low_rd_r <= lm[cmd.rd_addr_a];
  end

  // pivot, multiplier and product registers
  always_ff @(posedge clk) begin
    if (cmd.piv_load) piv_r <= rd_a_r;
    if (cmd.flag_set) mu_r <= '0;
    else if (div_done) mu_r <= div_quot;
    if (cmd.mul_en) begin
      prod_r <= $signed({{(64-W){mu_r[W-1]}}, mu_r}) * $signed({{(64-W){rd_a_r[W-1]}}, rd_a_r});
      akj_r  <= rd_b_r;
    end
  end

  // error flag and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.flag_clr) flag_r <= 1'b0;
      else if (cmd.flag_set) flag_r <= 1'b1;
      out_strobe_r <= cmd.out_cap;
    end
    if (cmd.out_cap) begin
      out_last_r <= cmd.out_last;
      if (cmd.out_below) begin
        out_lower_r <= low_rd_r;
        out_upper_r <= '0;
      end else begin
        out_lower_r <= cmd.out_diag ? lud_pkg::sat(lud_pkg::Q_ONE) : '0;
        out_upper_r <= rd_a_r;
      end
    end
  end

  assign sts.piv_zero   = (piv_r == '0);
  assign sts.div_done   = div_done;
  assign out_lower_value = out_lower_r;
  assign out_upper_value = out_upper_r;
  assign out_last_result = out_last_r;
  assign out_pivot_error = flag_r;
  assign out_strobe      = out_strobe_r;

endmodule

// ----- rtl/lud_controller.sv -----
`timescale 1ns / 1ps

module lud_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_last_element,
  output logic                        busy,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lud_pkg::SIZE_W-1:0]  cfg_matrix_size,
  output lud_pkg::lud_cmd_t           cmd,
  input  lud_pkg::lud_sts_t           sts
);

  localparam int CW = lud_pkg::CNT_W;
  localparam int LW = lud_pkg::LCNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_COL   = 4'd2;
  localparam logic [3:0] S_COLW  = 4'd3;
  localparam logic [3:0] S_ROWRD = 4'd4;
  localparam logic [3:0] S_DIVS  = 4'd5;
  localparam logic [3:0] S_DIVW  = 4'd6;
  localparam logic [3:0] S_LOWWR = 4'd7;
  localparam logic [3:0] S_UPRD  = 4'd8;
  localparam logic [3:0] S_UPMUL = 4'd9;
  localparam logic [3:0] S_UPWR  = 4'd10;
  localparam logic [3:0] S_NXTK  = 4'd11;
  localparam logic [3:0] S_OUTRD = 4'd12;
  localparam logic [3:0] S_OUTEM = 4'd13;

  logic [3:0]                state_r, state_nxt;
  logic [lud_pkg::SIZE_W-1:0] size_r;
  logic [LW-1:0]             lcnt_r, lcnt_nxt;
  logic [CW-1:0]             i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [CW-1:0]             n;
  logic [LW-1:0]             total;
  logic [2*CW-1:0]           total_w;
  logic                      i_more, j_more, k_more;

  // clamp the order into range
  always_comb begin
    if (size_r == '0) n = CW'(1);
    else if (size_r > lud_pkg::SIZE_W'(lud_pkg::MAX_ORDER)) n = CW'(lud_pkg::MAX_ORDER);
    else n = CW'(size_r);
  end

  assign total_w = (2*CW)'(n) * (2*CW)'(n);
  assign total   = total_w[LW-1:0];
  assign i_more  = ({1'b0, i_r} + (CW+1)'(1)) < {1'b0, n};
  assign j_more  = ({1'b0, j_r} + (CW+1)'(1)) < {1'b0, n};
  assign k_more  = ({1'b0, k_r} + (CW+1)'(1)) < {1'b0, n};

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    state_nxt = state_r;
    lcnt_nxt  = lcnt_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.wr_sel = lud_pkg::WR_LOAD;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (lcnt_r < total) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = lcnt_r[lud_pkg::ADDR_W-1:0];
            lcnt_nxt    = lcnt_r + LW'(1);
          end
          if (in_last_element) begin
            cmd.flag_clr = 1'b1;
            state_nxt    = S_FILL;
          end
        end
      end
      // zero what this run did not load
      S_FILL: begin
        if (lcnt_r < total) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = lud_pkg::WR_ZERO;
          cmd.wr_addr = lcnt_r[lud_pkg::ADDR_W-1:0];
          lcnt_nxt    = lcnt_r + LW'(1);
        end else begin
          lcnt_nxt  = '0;
          i_nxt     = '0;
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        if (i_more) begin
          cmd.rd_addr_a = lud_pkg::lin(i_r, i_r, n);
          state_nxt     = S_COLW;
        end else begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_OUTRD;
        end
      end
      S_COLW: begin
        cmd.piv_load = 1'b1;
        k_nxt        = i_r + CW'(1);
        state_nxt    = S_ROWRD;
      end
      S_ROWRD: begin
        cmd.rd_addr_a = lud_pkg::lin(k_r, i_r, n);
        state_nxt     = S_DIVS;
      end
      S_DIVS: begin
        if (sts.piv_zero) begin
          cmd.flag_set = 1'b1;
          state_nxt    = S_LOWWR;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts.div_done) state_nxt = S_LOWWR;
      end
      S_LOWWR: begin
        cmd.low_wr  = 1'b1;
        cmd.wr_addr = lud_pkg::lin(k_r, i_r, n);
        if (sts.piv_zero) begin
          state_nxt = S_NXTK;
        end else begin
          j_nxt     = i_r + CW'(1);
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        cmd.rd_addr_a = lud_pkg::lin(i_r, j_r, n);
        cmd.rd_addr_b = lud_pkg::lin(k_r, j_r, n);
        state_nxt     = S_UPMUL;
      end
      S_UPMUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_UPWR;
      end
      S_UPWR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = lud_pkg::WR_UPD;
        cmd.wr_addr = lud_pkg::lin(k_r, j_r, n);
        if (j_more) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_UPRD;
        end else begin
          state_nxt = S_NXTK;
        end
      end
      S_NXTK: begin
        if (k_more) begin
          k_nxt     = k_r + CW'(1);
          state_nxt = S_ROWRD;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_COL;
        end
      end
      S_OUTRD: begin
        cmd.rd_addr_a = lud_pkg::lin(i_r, j_r, n);
        state_nxt     = S_OUTEM;
      end
      // emit one position, then advance in row-major order
      S_OUTEM: begin
        cmd.out_cap   = 1'b1;
        cmd.out_below = (i_r > j_r);
        cmd.out_diag  = (i_r == j_r);
        cmd.out_last  = !i_more && !j_more;
        if (!i_more && !j_more) begin
          state_nxt = S_IDLE;
        end else if (j_more) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_OUTRD;
        end else begin
          j_nxt     = '0;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_OUTRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= lud_pkg::SIZE_RESET;
      lcnt_r  <= '0;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      lcnt_r  <= lcnt_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      if (cfg_valid && cfg_ready) size_r <= cfg_matrix_size;
    end
  end

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_cap |=> !cmd.out_cap)
    else $error("result emitted on two cycles in a row");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.piv_zero)
    else $error("division started with a zero pivot");

  a_update_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPRD) |-> (j_r < n && k_r < n && i_r < j_r))
    else $error("update index out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE))
    else $error("controller not idle after reset");

endmodule
